>>> rtl/tqs_pkg.sv
// Package for the triangle quality scorer: register indexes, reset values
// and the fixed-point constants shared by the datapath.
// Depends on nothing.
`default_nettype none

package tqs_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SKEW_WEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_LIMIT  = 3'd5;

  localparam logic [31:0] RST_WEIGHT      = 32'd65536;
  localparam logic [16:0] RST_SKEW_LIMIT  = 17'd65536;
  localparam logic [31:0] RST_LIMIT       = 32'd655360;

  localparam logic [31:0] SAT32  = 32'hFFFF_FFFF;
  localparam logic [30:0] ONE30  = 31'h4000_0000;
  // 8 / (3 * sqrt(3)) in Q1.30
  localparam logic [30:0] K_EQUI = 31'd1653133683;

  typedef struct packed {
    logic [2:0]  k;
    logic [31:0] mean;
  } root_side_t;

endpackage

`default_nettype wire

>>> rtl/tqs_sqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes
// in step. Standalone; no package needed.
`default_nettype none

module tqs_sqrt #(
  parameter int LANES  = 4,
  parameter int OUT_W  = 60,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [SIDE_W-1:0]    in_side,
  input  logic [2*OUT_W-1:0]   radicand [LANES],
  output logic                 out_valid,
  output logic [SIDE_W-1:0]    out_side,
  output logic [OUT_W-1:0]     root [LANES]
);

  localparam int RW = 2 * OUT_W + 1;

  logic [RW-1:0]     rem_q  [OUT_W][LANES];
  logic [OUT_W-1:0]  rt_q   [OUT_W][LANES];
  logic              vld_q  [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    localparam int B = OUT_W - 1 - s;
    logic [RW-1:0]     rem_i [LANES];
    logic [OUT_W-1:0]  rt_i  [LANES];
    logic [RW-1:0]     trial [LANES];
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = RW'(radicand[l]);
          rt_i[l]  = '0;
        end
      end
      assign vld_i  = in_valid;
      assign side_i = in_side;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = rem_q[s-1][l];
          rt_i[l]  = rt_q[s-1][l];
        end
      end
      assign vld_i  = vld_q[s-1];
      assign side_i = side_q[s-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = (RW'(rt_i[l]) << (B + 1)) | (RW'(1) << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s] <= side_i;
        for (int l = 0; l < LANES; l++) begin
          if (rem_i[l] >= trial[l]) begin
            rem_q[s][l] <= rem_i[l] - trial[l];
            rt_q[s][l]  <= rt_i[l] | (OUT_W'(1) << B);
          end else begin
            rem_q[s][l] <= rem_i[l];
            rt_q[s][l]  <= rt_i[l];
          end
        end
      end
    end
  end

  assign out_valid = vld_q[OUT_W-1];
  assign out_side  = side_q[OUT_W-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = rt_q[OUT_W-1][l];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tqs_div.sv
// Pipelined restoring divider giving floor(num / den) over Q_W quotient
// bits, with an overflow flag. Standalone; no package needed.
`default_nettype none

module tqs_div #(
  parameter int LANES  = 5,
  parameter int NUM_W  = 122,
  parameter int DEN_W  = 94,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den [LANES],
  output logic              out_valid,
  output logic [SIDE_W-1:0] out_side,
  output logic [Q_W-1:0]    quot [LANES],
  output logic              ovf  [LANES]
);

  localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [W-1:0]      rem_q  [Q_W+1][LANES];
  logic [DEN_W-1:0]  den_q  [Q_W+1][LANES];
  logic [Q_W-1:0]    q_q    [Q_W+1][LANES];
  logic              ovf_q  [Q_W+1][LANES];
  logic              vld_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];

  // First stage: a zero divisor or a quotient of 2^Q_W or more overflows.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= W'(num[l]);
        den_q[0][l] <= den[l];
        q_q[0][l]   <= '0;
        ovf_q[0][l] <= (den[l] == '0) || (W'(num[l]) >= (W'(den[l]) << Q_W));
      end
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int I = Q_W - j;
    logic [W-1:0] trial [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = W'(den_q[j-1][l]) << I;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= side_q[j-1];
        for (int l = 0; l < LANES; l++) begin
          den_q[j][l] <= den_q[j-1][l];
          ovf_q[j][l] <= ovf_q[j-1][l];
          if (rem_q[j-1][l] >= trial[l]) begin
            rem_q[j][l] <= rem_q[j-1][l] - trial[l];
            q_q[j][l]   <= q_q[j-1][l] | (Q_W'(1) << I);
          end else begin
            rem_q[j][l] <= rem_q[j-1][l];
            q_q[j][l]   <= q_q[j-1][l];
          end
        end
      end
    end
  end

  assign out_valid = vld_q[Q_W];
  assign out_side  = side_q[Q_W];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot[l] = q_q[Q_W][l];
      ovf[l]  = ovf_q[Q_W][l];
    end
  end

endmodule

`default_nettype wire

>>> rtl/triangle_quality_score.sv
// Top level of the triangle quality scorer: edge set-up, cross product,
// roots, divisions and the weighted score.
// Depends on tqs_pkg, tqs_sqrt and tqs_div.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | s_tvalid s_tready s_tdata[319:0]            | into block
//  out     | m_tvalid m_tready m_tdata[31:0] m_tuser[1:0] | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | into block
//
// One triangle is taken per cycle while s_tready is high; each goes through
// 109 register stages, set by the 60-stage square root of the cross product
// norm followed by the 33-stage divider. When the receiver stalls, the result
// at the output moves into a one-entry holding register; while that register
// is full the whole pipeline holds and s_tready is low, so s_tready never
// depends on m_tready. Reset clears the valid bits and loads the register
// defaults. The configuration port is always ready.
`default_nettype none

module triangle_quality_score #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, mean_area (32 bits each)
  input  logic [319:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // score
  output logic [31:0]  m_tdata,
  // passed, degenerate
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  import tqs_pkg::*;

  localparam int Y_W  = 33 + COORD_FRAC_BITS;
  localparam int RN_W = (Y_W > 68) ? Y_W : 68;

  // ---------------- configuration ----------------
  logic [31:0] skew_weight, area_weight, aspect_weight;
  logic [31:0] area_ratio_limit, aspect_limit;
  logic [16:0] skew_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      skew_weight      <= RST_WEIGHT;
      area_weight      <= RST_WEIGHT;
      aspect_weight    <= RST_WEIGHT;
      skew_limit       <= RST_SKEW_LIMIT;
      area_ratio_limit <= RST_LIMIT;
      aspect_limit     <= RST_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SKEW_WEIGHT:   skew_weight      <= cfg_data;
        REG_AREA_WEIGHT:   area_weight      <= cfg_data;
        REG_ASPECT_WEIGHT: aspect_weight    <= cfg_data;
        REG_SKEW_LIMIT:    skew_limit       <= cfg_data[16:0];
        REG_AREA_LIMIT:    area_ratio_limit <= cfg_data;
        REG_ASPECT_LIMIT:  aspect_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic u1, u2;
  logic w1, w2, w3, w4, w5, w6, w7;
  logic sq_valid, dv_valid;
  logic        hold_v;
  logic [31:0] hold_score;
  logic [1:0]  hold_flags;
  logic [31:0] score_o;
  logic        passed_o, degen_o;

  assign en       = !hold_v;
  assign s_tready = en;
  assign m_tvalid = w7 || hold_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
      {u1, u2} <= '0;
      {w1, w2, w3, w4, w5, w6, w7} <= '0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      u1 <= sq_valid;
      u2 <= u1;
      w1 <= dv_valid;
      w2 <= w1;
      w3 <= w2;
      w4 <= w3;
      w5 <= w4;
      w6 <= w5;
      w7 <= w6;
    end
  end

  // The holding register takes the last stage's result when the receiver
  // stalls, since the pipeline still advances in that cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (hold_v) begin
      if (m_tready) hold_v <= 1'b0;
    end else if (w7 && !m_tready) begin
      hold_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_v) begin
      hold_score <= score_o;
      hold_flags <= {degen_o, passed_o};
    end
  end

  // ---------------- edge set-up and range reduction ----------------
  logic signed [31:0] va [3], vb [3], vc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = s_tdata[32*i +: 32];
      vb[i] = s_tdata[32*(3+i) +: 32];
      vc[i] = s_tdata[32*(6+i) +: 32];
    end
  end

  logic [32:0] d0_1 [3], d1_1 [3];
  logic [31:0] mean_1, mean_2, mean_3, mean_4, mean_5, mean_6, mean_7;
  logic [32:0] m0_2 [3], m1_2 [3];
  logic        n0_2 [3], n1_2 [3];
  logic [2:0]  k_2, k_3, k_4, k_5, k_6, k_7;
  logic signed [29:0] e0_3 [3], e1_3 [3];
  logic signed [30:0] e2_4 [3];
  logic signed [59:0] cp_4 [6];
  logic [57:0] s0_4 [3], s1_4 [3];
  logic [60:0] n_5 [3];
  logic [59:0] qab_5, qac_5, s2_5 [3];
  logic [59:0] qab_6, qac_6, qab_7, qac_7;
  logic [61:0] qbc_6, qbc_7;
  logic [57:0] hh_6 [3];
  logic [58:0] hl_6 [3];
  logic [59:0] ll_6 [3];
  logic [119:0] nsq_7;

  logic [32:0] m0_c [3], m1_c [3], or_m;
  logic [2:0]  k_c;
  logic [58:0] nmag_c [3];

  always_comb begin
    or_m = '0;
    for (int i = 0; i < 3; i++) begin
      m0_c[i] = d0_1[i][32] ? (~d0_1[i] + 33'd1) : d0_1[i];
      m1_c[i] = d1_1[i][32] ? (~d1_1[i] + 33'd1) : d1_1[i];
      or_m    = or_m | m0_c[i] | m1_c[i];
    end
    // Smallest shift that brings every magnitude below 2^29.
    if (or_m[32])      k_c = 3'd4;
    else if (or_m[31]) k_c = 3'd3;
    else if (or_m[30]) k_c = 3'd2;
    else if (or_m[29]) k_c = 3'd1;
    else               k_c = 3'd0;
    for (int i = 0; i < 3; i++) begin
      nmag_c[i] = n_5[i][60] ? 59'(~n_5[i] + 61'd1) : n_5[i][58:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: edge vectors AB and AC
      for (int i = 0; i < 3; i++) begin
        d0_1[i] <= {vb[i][31], vb[i]} - {va[i][31], va[i]};
        d1_1[i] <= {vc[i][31], vc[i]} - {va[i][31], va[i]};
      end
      mean_1 <= s_tdata[319:288];
      // stage 2: magnitudes and shift
      for (int i = 0; i < 3; i++) begin
        m0_2[i] <= m0_c[i];
        m1_2[i] <= m1_c[i];
        n0_2[i] <= d0_1[i][32];
        n1_2[i] <= d1_1[i][32];
      end
      k_2    <= k_c;
      mean_2 <= mean_1;
      // stage 3: reduced components, magnitude truncated then sign restored
      for (int i = 0; i < 3; i++) begin
        e0_3[i] <= n0_2[i] ? -$signed({1'b0, 29'(m0_2[i] >> k_2)})
                           :  $signed({1'b0, 29'(m0_2[i] >> k_2)});
        e1_3[i] <= n1_2[i] ? -$signed({1'b0, 29'(m1_2[i] >> k_2)})
                           :  $signed({1'b0, 29'(m1_2[i] >> k_2)});
      end
      k_3    <= k_2;
      mean_3 <= mean_2;
      // stage 4: edge BC, cross product terms, squares
      for (int i = 0; i < 3; i++) begin
        e2_4[i] <= 31'(e1_3[i]) - 31'(e0_3[i]);
        s0_4[i] <= 58'(60'(e0_3[i] * e0_3[i]));
        s1_4[i] <= 58'(60'(e1_3[i] * e1_3[i]));
      end
      cp_4[0] <= e0_3[1] * e1_3[2];
      cp_4[1] <= e0_3[2] * e1_3[1];
      cp_4[2] <= e0_3[2] * e1_3[0];
      cp_4[3] <= e0_3[0] * e1_3[2];
      cp_4[4] <= e0_3[0] * e1_3[1];
      cp_4[5] <= e0_3[1] * e1_3[0];
      k_4    <= k_3;
      mean_4 <= mean_3;
      // stage 5: normal vector, squared lengths of AB and AC, squares of BC's parts
      for (int i = 0; i < 3; i++) begin
        n_5[i]  <= 61'(cp_4[2*i]) - 61'(cp_4[2*i+1]);
        s2_5[i] <= 60'(62'(e2_4[i] * e2_4[i]));
      end
      qab_5  <= 60'(s0_4[0]) + 60'(s0_4[1]) + 60'(s0_4[2]);
      qac_5  <= 60'(s1_4[0]) + 60'(s1_4[1]) + 60'(s1_4[2]);
      k_5    <= k_4;
      mean_5 <= mean_4;
      // stage 6: partial products of the normal's squares, squared length of BC
      for (int i = 0; i < 3; i++) begin
        hh_6[i] <= 58'(nmag_c[i][58:30]) * 58'(nmag_c[i][58:30]);
        hl_6[i] <= 59'(nmag_c[i][58:30]) * 59'(nmag_c[i][29:0]);
        ll_6[i] <= 60'(nmag_c[i][29:0]) * 60'(nmag_c[i][29:0]);
      end
      qbc_6  <= 62'(s2_5[0]) + 62'(s2_5[1]) + 62'(s2_5[2]);
      qab_6  <= qab_5;
      qac_6  <= qac_5;
      k_6    <= k_5;
      mean_6 <= mean_5;
      // stage 7: |N|^2
      nsq_7 <= (120'(hh_6[0]) << 60) + (120'(hl_6[0]) << 31) + 120'(ll_6[0])
             + (120'(hh_6[1]) << 60) + (120'(hl_6[1]) << 31) + 120'(ll_6[1])
             + (120'(hh_6[2]) << 60) + (120'(hl_6[2]) << 31) + 120'(ll_6[2]);
      qab_7  <= qab_6;
      qac_7  <= qac_6;
      qbc_7  <= qbc_6;
      k_7    <= k_6;
      mean_7 <= mean_6;
    end
  end

  // ---------------- square roots ----------------
  logic [119:0] rad [4];
  logic [59:0]  rt  [4];
  root_side_t   sq_side_in, sq_side;

  assign sq_side_in.k    = k_7;
  assign sq_side_in.mean = mean_7;
  assign rad[0] = nsq_7;
  assign rad[1] = 120'(qab_7) << 32;
  assign rad[2] = 120'(qac_7) << 32;
  assign rad[3] = 120'(qbc_7) << 32;

  tqs_sqrt #(
    .LANES  (4),
    .OUT_W  (60),
    .SIDE_W ($bits(root_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_side   (sq_side_in),
    .radicand  (rad),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .root      (rt)
  );

  // ---------------- denominators ----------------
  logic [46:0] lab, lac, lbc;
  assign lab = rt[1][46:0];
  assign lac = rt[2][46:0];
  assign lbc = rt[3][46:0];

  logic [RN_W-1:0] x_c, y_c;
  logic [46:0]     lon_c, sho_c;
  always_comb begin
    x_c = RN_W'(rt[0]) << {sq_side.k, 1'b0};
    y_c = RN_W'(sq_side.mean) << (COORD_FRAC_BITS + 1);
    lon_c = lab;
    sho_c = lab;
    if (lac > lon_c) lon_c = lac;
    if (lbc > lon_c) lon_c = lbc;
    if (lac < sho_c) sho_c = lac;
    if (lbc < sho_c) sho_c = lbc;
  end

  logic [59:0]     dd_1, dd_2;
  logic            dg_1, dg_2;
  logic [45:0]     phh_1 [3];
  logic [46:0]     phl_1 [3], plh_1 [3];
  logic [47:0]     pll_1 [3];
  logic [RN_W-1:0] rnum_1, rden_1, rnum_2, rden_2;
  logic [46:0]     lon_1, sho_1, sho_2, dif_2;
  logic [93:0]     den_2 [3];
  logic [46:0]     pa [3], pb [3];

  assign pa[0] = lab;  assign pb[0] = lac;
  assign pa[1] = lab;  assign pb[1] = lbc;
  assign pa[2] = lac;  assign pb[2] = lbc;

  always_ff @(posedge clk) begin
    if (en) begin
      dd_1 <= rt[0];
      dg_1 <= (rt[0] == '0) || (lab == '0) || (lac == '0) || (lbc == '0);
      for (int i = 0; i < 3; i++) begin
        phh_1[i] <= 46'(pa[i][46:24]) * 46'(pb[i][46:24]);
        phl_1[i] <= 47'(pa[i][46:24]) * 47'(pb[i][23:0]);
        plh_1[i] <= 47'(pa[i][23:0]) * 47'(pb[i][46:24]);
        pll_1[i] <= 48'(pa[i][23:0]) * 48'(pb[i][23:0]);
      end
      rnum_1 <= (x_c >= y_c) ? x_c : y_c;
      rden_1 <= (x_c >= y_c) ? y_c : x_c;
      lon_1  <= lon_c;
      sho_1  <= sho_c;

      dd_2 <= dd_1;
      dg_2 <= dg_1;
      for (int i = 0; i < 3; i++) begin
        den_2[i] <= (94'(phh_1[i]) << 48) + (94'(phl_1[i]) << 24)
                  + (94'(plh_1[i]) << 24) + 94'(pll_1[i]);
      end
      rnum_2 <= rnum_1;
      rden_2 <= rden_1;
      sho_2  <= sho_1;
      dif_2  <= lon_1 - sho_1;
    end
  end

  // ---------------- divisions ----------------
  // Lanes 0..2 give the three sines, lane 3 the area ratio, lane 4 the aspect.
  logic [121:0] dnum [5];
  logic [93:0]  dden [5];
  logic [31:0]  dq   [5];
  logic         dovf [5];
  logic         dv_dg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dnum[i] = 122'(dd_2) << 62;
      dden[i] = den_2[i];
    end
    dnum[3] = 122'(rnum_2) << 16;
    dden[3] = 94'(rden_2);
    dnum[4] = 122'(dif_2) << 16;
    dden[4] = 94'(sho_2);
  end

  tqs_div #(
    .LANES  (5),
    .NUM_W  (122),
    .DEN_W  (94),
    .Q_W    (32),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (u2),
    .in_side   (dg_2),
    .num       (dnum),
    .den       (dden),
    .out_valid (dv_valid),
    .out_side  (dv_dg),
    .quot      (dq),
    .ovf       (dovf)
  );

  // ---------------- skewness and score ----------------
  logic [30:0] sn_1 [3];
  logic [31:0] ratio_1, aspect_1;
  logic        dg_w1, dg_w2, dg_w3, dg_w4, dg_w5, dg_w6;
  logic [30:0] p1_2, sc_2, p_3, r30_4;
  logic [47:0] at_2, at_3, at_4, at_5, at_6;
  logic [47:0] pt_2, pt_3, pt_4, pt_5, pt_6;
  logic        rf_2, rf_3, rf_4, rf_5, rf_6;
  logic [16:0] skew_5;
  logic        sf_6;
  logic [32:0] st_6;
  logic [61:0] kp_c;
  logic [49:0] total_c;

  assign kp_c    = 62'(K_EQUI) * 62'(p_3);
  assign total_c = 50'(st_6) + 50'(at_6) + 50'(pt_6);

  always_ff @(posedge clk) begin
    if (en) begin
      // sines capped at 1.0, ratio and aspect saturated on overflow
      for (int i = 0; i < 3; i++) begin
        sn_1[i] <= (dovf[i] || dq[i] >= 32'(ONE30)) ? ONE30 : dq[i][30:0];
      end
      ratio_1  <= dovf[3] ? SAT32 : dq[3];
      aspect_1 <= dovf[4] ? SAT32 : dq[4];
      dg_w1    <= dv_dg;

      p1_2  <= 31'((62'(sn_1[0]) * 62'(sn_1[1])) >> 30);
      sc_2  <= sn_1[2];
      at_2  <= 48'((64'(area_weight) * 64'(ratio_1)) >> 16);
      pt_2  <= 48'((64'(aspect_weight) * 64'(aspect_1)) >> 16);
      rf_2  <= (ratio_1 > area_ratio_limit) || (aspect_1 > aspect_limit);
      dg_w2 <= dg_w1;

      p_3   <= 31'((62'(p1_2) * 62'(sc_2)) >> 30);
      at_3  <= at_2;
      pt_3  <= pt_2;
      rf_3  <= rf_2;
      dg_w3 <= dg_w2;

      r30_4 <= (kp_c[61:30] > 32'(ONE30)) ? ONE30 : kp_c[60:30];
      at_4  <= at_3;
      pt_4  <= pt_3;
      rf_4  <= rf_3;
      dg_w4 <= dg_w3;

      skew_5 <= 17'((ONE30 - r30_4) >> 14);
      at_5   <= at_4;
      pt_5   <= pt_4;
      rf_5   <= rf_4;
      dg_w5  <= dg_w4;

      st_6  <= 33'((49'(skew_weight) * 49'(skew_5)) >> 16);
      sf_6  <= skew_5 >= skew_limit;
      at_6  <= at_5;
      pt_6  <= pt_5;
      rf_6  <= rf_5;
      dg_w6 <= dg_w5;

      // a degenerate triangle overrides everything else
      if (dg_w6) begin
        score_o  <= SAT32;
        passed_o <= 1'b0;
      end else begin
        score_o  <= (total_c > 50'(SAT32)) ? SAT32 : total_c[31:0];
        passed_o <= !(sf_6 || rf_6);
      end
      degen_o <= dg_w6;
    end
  end

  assign m_tdata = hold_v ? hold_score : score_o;
  assign m_tuser = hold_v ? hold_flags : {degen_o, passed_o};

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for triangle_quality_score: random and directed
// triangles, register changes between phases, checked against an internal model.
// Depends on tqs_pkg and the RTL of triangle_quality_score.
`timescale 1ns / 1ps

module testbench;
  import tqs_pkg::*;

  typedef struct {
    logic [31:0] v[9];
    logic [31:0] mean;
  } tri_t;

  typedef struct {
    logic [31:0] score;
    logic        passed;
    logic        degen;
  } grade_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [319:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  triangle_quality_score uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Register copies used by the predictor.
  logic [31:0] w_skew, w_area, w_aspect, lim_area, lim_aspect;
  logic [16:0] lim_skew;

  tri_t   pending_tris[$];
  grade_t expected_grades[$];
  int     errors = 0;
  int     burst_left = 0, gap_left = 0;
  int     hold_off = 0;
  bit     stall_mode = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void add_tri(input tri_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Capped floor(n * 2^fb / d).
  function automatic logic [63:0] capped_quot(input logic [127:0] n, input logic [127:0] d,
                                              input int fb, input logic [63:0] cap);
    logic [191:0] num, q;
    if (d == 0) return cap;
    num = {64'd0, n} << fb;
    if (num >= ({64'd0, d} << 32)) return cap;
    q = num / {64'd0, d};
    return (q[63:0] < cap) ? q[63:0] : cap;
  endfunction

  function automatic grade_t grade_triangle(input tri_t t);
    grade_t g;
    longint e0[3], e1[3], e2[3], nv[3];
    logic [63:0] m, mg, dd, lab, lac, lbc, sa, sb, sc, p, r30, skew, ratio, aspect;
    logic [63:0] lon, sho;
    logic [127:0] qab, qac, qbc, x, y;
    logic [65:0] sum;
    int k;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      e0[i] = longint'($signed(t.v[3+i])) - longint'($signed(t.v[i]));
      e1[i] = longint'($signed(t.v[6+i])) - longint'($signed(t.v[i]));
      mg = e0[i] < 0 ? -e0[i] : e0[i];
      if (mg > m) m = mg;
      mg = e1[i] < 0 ? -e1[i] : e1[i];
      if (mg > m) m = mg;
    end
    k = 0;
    while (k < 4 && (m >> k) >= (64'd1 << 29)) k++;
    for (int i = 0; i < 3; i++) begin
      e0[i] = e0[i] < 0 ? -((-e0[i]) >>> k) : (e0[i] >>> k);
      e1[i] = e1[i] < 0 ? -((-e1[i]) >>> k) : (e1[i] >>> k);
      e2[i] = e1[i] - e0[i];
    end
    nv[0] = e0[1] * e1[2] - e0[2] * e1[1];
    nv[1] = e0[2] * e1[0] - e0[0] * e1[2];
    nv[2] = e0[0] * e1[1] - e0[1] * e1[0];
    x = 0; qab = 0; qac = 0; qbc = 0;
    for (int i = 0; i < 3; i++) begin
      mg = nv[i] < 0 ? -nv[i] : nv[i];
      x += {64'd0, mg} * {64'd0, mg};
      qab += 128'(e0[i] * e0[i]);
      qac += 128'(e1[i] * e1[i]);
      qbc += 128'(e2[i] * e2[i]);
    end
    dd = isqrt(x);
    if (dd == 0 || qab == 0 || qac == 0 || qbc == 0) begin
      g.score = SAT32; g.passed = 0; g.degen = 1;
      return g;
    end
    lab = isqrt(qab << 32);
    lac = isqrt(qac << 32);
    lbc = isqrt(qbc << 32);
    x = {64'd0, dd} << 32;
    sa = capped_quot(x, {64'd0, lab} * {64'd0, lac}, 30, 64'd1 << 30);
    sb = capped_quot(x, {64'd0, lab} * {64'd0, lbc}, 30, 64'd1 << 30);
    sc = capped_quot(x, {64'd0, lac} * {64'd0, lbc}, 30, 64'd1 << 30);
    p = (((sa * sb) >> 30) * sc) >> 30;
    r30 = (64'(K_EQUI) * p) >> 30;
    if (r30 > (64'd1 << 30)) r30 = 64'd1 << 30;
    skew = ((64'd1 << 30) - r30) >> 14;
    x = {64'd0, dd} << (2 * k);
    y = {96'd0, t.mean} << 17;
    ratio = (x >= y) ? capped_quot(x, y, 16, SAT32) : capped_quot(y, x, 16, SAT32);
    lon = lab; sho = lab;
    if (lac > lon) lon = lac;
    if (lbc > lon) lon = lbc;
    if (lac < sho) sho = lac;
    if (lbc < sho) sho = lbc;
    aspect = capped_quot(lon - sho, sho, 16, SAT32);
    sum = 66'((64'(w_skew) * skew) >> 16) + 66'((64'(w_area) * ratio) >> 16)
        + 66'((64'(w_aspect) * aspect) >> 16);
    g.score = sum > SAT32 ? SAT32 : sum[31:0];
    g.passed = !(skew >= lim_skew || ratio > lim_area || aspect > lim_aspect);
    g.degen = 0;
    return g;
  endfunction

  // Driver: bursts of offered triangles separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) void'(pending_tris.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 0;
      end else if (pending_tris.size() > 0) begin
        s_tvalid <= 1;
        for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] <= pending_tris[0].v[i];
        s_tdata[288 +: 32] <= pending_tris[0].mean;
        expected_grades.insert(expected_grades.size(), grade_triangle(pending_tris[0]));
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off--;
      m_tready <= 0;
    end else begin
      m_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    grade_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_grades.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_grades.pop_front();
        if (m_tdata !== e.score)
          report($sformatf("score got %h want %h", m_tdata, e.score));
        if (m_tuser[0] !== e.passed)
          report($sformatf("passed got %b want %b", m_tuser[0], e.passed));
        if (m_tuser[1] !== e.degen)
          report($sformatf("degenerate got %b want %b", m_tuser[1], e.degen));
      end
    end
  end

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SKEW_WEIGHT:   w_skew = val;
      REG_AREA_WEIGHT:   w_area = val;
      REG_ASPECT_WEIGHT: w_aspect = val;
      REG_SKEW_LIMIT:    lim_skew = val[16:0];
      REG_AREA_LIMIT:    lim_area = val;
      REG_ASPECT_LIMIT:  lim_aspect = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_tris.size() > 0 || expected_grades.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic tri_t random_tri(input int style);
    tri_t t;
    logic [31:0] base;
    for (int i = 0; i < 9; i++) t.v[i] = $urandom;
    t.mean = $urandom;
    case (style)
      0: begin  // modest triangle around a random origin
        base = $urandom_range(0, 32'hFFFF) << 10;
        for (int i = 0; i < 9; i++)
          t.v[i] = base + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
        t.mean = $urandom_range(1, 32'h3FFFF);
      end
      1: begin  // near-equilateral in the xy plane
        base = $urandom_range(1, 32'hFFFFF);
        t.v = '{0, 0, 0, base, 0, 0, base / 2, (base * 887) >> 10, 0};
        t.mean = $urandom_range(1, 32'h7FFFFFF);
      end
      2: begin  // collinear or repeated vertices
        base = $urandom;
        for (int i = 0; i < 3; i++) begin
          t.v[i] = base + i; t.v[3+i] = base + 2 * i; t.v[6+i] = base + 3 * i;
        end
        if ($urandom_range(0, 1)) t.v[3:5] = t.v[0:2];
      end
      3: t.mean = $urandom_range(0, 1) ? 32'd1 : SAT32;
      default: ;
    endcase
    if (t.mean == 0) t.mean = 1;
    return t;
  endfunction

  initial begin
    tri_t t;
    w_skew = RST_WEIGHT; w_area = RST_WEIGHT; w_aspect = RST_WEIGHT;
    lim_skew = RST_SKEW_LIMIT; lim_area = RST_LIMIT; lim_aspect = RST_LIMIT;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: unit triangle, extremes of the coordinates and mean area.
    t.v = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}; t.mean = 32'h8000;
    add_tri(t);
    t.v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
    t.mean = SAT32; add_tri(t);
    t.mean = 1; add_tri(t);
    t.v = '{5, 5, 5, 5, 5, 5, 9, 9, 9}; add_tri(t);    // repeated vertex
    t.v = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; add_tri(t);    // collinear
    t.v = '{0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 1, 0}; add_tri(t);  // needle
    t.v = '{0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0}; add_tri(t);
    t.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; t.mean = 1; add_tri(t);
    t.v = '{32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF};
    add_tri(t);
    for (int i = 0; i < 8; i++) add_tri(random_tri(i % 4));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SKEW_WEIGHT, 0); write_reg(REG_AREA_WEIGHT, 0);
          write_reg(REG_ASPECT_WEIGHT, 0); write_reg(REG_SKEW_LIMIT, 0);
          write_reg(REG_AREA_LIMIT, 32'h10000); write_reg(REG_ASPECT_LIMIT, 0);
        end
        1: begin
          write_reg(REG_SKEW_WEIGHT, SAT32); write_reg(REG_AREA_WEIGHT, SAT32);
          write_reg(REG_ASPECT_WEIGHT, SAT32); write_reg(REG_SKEW_LIMIT, 32'h10000);
          write_reg(REG_AREA_LIMIT, SAT32); write_reg(REG_ASPECT_LIMIT, SAT32);
          write_reg(3'd7, 32'h1234);  // unused index, must be ignored
        end
        default: begin
          write_reg(REG_SKEW_WEIGHT, $urandom_range(0, 32'h40000));
          write_reg(REG_AREA_WEIGHT, $urandom_range(0, 32'h40000));
          write_reg(REG_ASPECT_WEIGHT, $urandom_range(0, 32'h40000));
          write_reg(REG_SKEW_LIMIT, $urandom_range(0, 32'h1FFFF));
          write_reg(REG_AREA_LIMIT, $urandom_range(32'h10000, 32'h200000));
          write_reg(REG_ASPECT_LIMIT, $urandom);
        end
      endcase
      cfg_valid <= 0;
      stall_mode = phase[0];
      for (int i = 0; i < 400; i++) add_tri(random_tri($urandom_range(0, 5)));
      if (phase == 2) begin
        // Let the pipeline fill while the output is held off.
        while (pending_tris.size() > 300) @(posedge clk);
        hold_off = 300;
      end
      drain();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
rtl/tqs_pkg.sv
rtl/tqs_sqrt.sv
rtl/tqs_div.sv
rtl/triangle_quality_score.sv
tb/sv/testbench.sv
